// ----- rtl/core/glms_pkg.sv -----
`timescale 1ns / 1ps

package glms_pkg;

	// Fixed field widths of the pixel and result beats.
	localparam int HEIGHT_W  = 4;
	localparam int SUM_W     = 17;
	localparam int COUNT_W   = 14;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	// Per-beat increments: up to four decisions of (1 + height) each.
	localparam int SUM_INC_W = 7;
	localparam int CNT_INC_W = 3;

	// Default frame store limits.
	localparam int MAX_WIDTH_DEF = 128;
	localparam int MAX_ROWS_DEF  = 128;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS  = 1'd1;
	localparam logic [CFG_W-1:0]     FRAME_WIDTH_RESET = 8'd100;
	localparam logic [CFG_W-1:0]     FRAME_ROWS_RESET  = 8'd100;

	// One row store entry: the row two above and the row just above.
	typedef struct packed {
		logic [HEIGHT_W-1:0] older;
		logic [HEIGHT_W-1:0] newer;
	} row_word_t;

	// Contribution of one accepted pixel beat to the frame totals.
	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic [SUM_INC_W-1:0] sum_inc;
		logic [CNT_INC_W-1:0] cnt_inc;
	} incr_t;

endpackage

// ----- rtl/core/glms_row_store.sv -----
`timescale 1ns / 1ps

module glms_row_store #(
	parameter int DEPTH = glms_pkg::MAX_WIDTH_DEF,
	parameter int AW    = 7
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  glms_pkg::row_word_t wr_data,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output glms_pkg::row_word_t rd_data
);

	glms_pkg::row_word_t mem [DEPTH];
	glms_pkg::row_word_t rd_data_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; a read of the entry being written returns the new word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (rd_addr == wr_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/glms_scan.sv -----
`timescale 1ns / 1ps

module glms_scan #(
	parameter int COL_W = 7,
	parameter int ROW_W = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               accept,
	input  logic [glms_pkg::HEIGHT_W-1:0]      pixel,
	input  logic [COL_W-1:0]                   col_last,
	input  logic [ROW_W-1:0]                   row_last,
	input  glms_pkg::row_word_t                rd_word,
	output logic                               wr_en,
	output logic [COL_W-1:0]                   wr_addr,
	output glms_pkg::row_word_t                wr_word,
	output logic                               rd_en,
	output logic [COL_W-1:0]                   rd_addr,
	output glms_pkg::incr_t                    incr
);

	localparam int HW = glms_pkg::HEIGHT_W;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Window of the previous beats in the same row.
	logic [HW-1:0] prev_center_q;  // row above, previous column
	logic [HW-1:0] prev_up_q;      // two rows above, previous column
	logic [HW-1:0] prev_pixel_q;   // current row, previous column
	logic [HW-1:0] prev2_center_q; // row above, two columns back
	logic [HW-1:0] prev2_pixel_q;  // current row, two columns back

	logic col_ge1, col_ge2, row_ge1, row_ge2, at_col_last, at_row_last;

	logic [3:0]    judge_en;
	logic [3:0]    judge_hit;
	logic [HW-1:0] judge_center [4];

	// True when the center is strictly lower than every neighbor that exists.
	function automatic logic is_min(
		input logic [HW-1:0] center,
		input logic          up_ok,
		input logic [HW-1:0] up,
		input logic          dn_ok,
		input logic [HW-1:0] dn,
		input logic          lf_ok,
		input logic [HW-1:0] lf,
		input logic          rt_ok,
		input logic [HW-1:0] rt
	);
		return !(up_ok && (up <= center)) && !(dn_ok && (dn <= center)) &&
			!(lf_ok && (lf <= center)) && !(rt_ok && (rt <= center));
	endfunction

	assign col_ge1     = (col_q != '0);
	assign col_ge2     = col_ge1 && (col_q != COL_W'(1));
	assign row_ge1     = (row_q != '0);
	assign row_ge2     = row_ge1 && (row_q != ROW_W'(1));
	assign at_col_last = (col_q == col_last);
	assign at_row_last = (row_q == row_last);

	// Row store access: shift the column down one row, prefetch the next column.
	assign wr_en         = accept;
	assign wr_addr       = col_q;
	assign wr_word.older = rd_word.newer;
	assign wr_word.newer = pixel;
	assign rd_en         = accept;
	assign rd_addr       = at_col_last ? '0 : col_q + COL_W'(1);

	// Up to four pixels are decided on one beat.
	always_comb begin
		// Row above, previous column: its right neighbor is now known.
		judge_en[0]     = row_ge1 && col_ge1;
		judge_center[0] = prev_center_q;
		judge_hit[0]    = is_min(prev_center_q, row_ge2, prev_up_q, 1'b1, prev_pixel_q,
			col_ge2, prev2_center_q, 1'b1, rd_word.newer);
		// Row above, last column.
		judge_en[1]     = row_ge1 && at_col_last;
		judge_center[1] = rd_word.newer;
		judge_hit[1]    = is_min(rd_word.newer, row_ge2, rd_word.older, 1'b1, pixel,
			col_ge1, prev_center_q, 1'b0, pixel);
		// Last row, previous column.
		judge_en[2]     = at_row_last && col_ge1;
		judge_center[2] = prev_pixel_q;
		judge_hit[2]    = is_min(prev_pixel_q, row_ge1, prev_center_q, 1'b0, pixel,
			col_ge2, prev2_pixel_q, 1'b1, pixel);
		// Last row, last column.
		judge_en[3]     = at_row_last && at_col_last;
		judge_center[3] = pixel;
		judge_hit[3]    = is_min(pixel, row_ge1, rd_word.newer, 1'b0, pixel,
			col_ge1, prev_pixel_q, 1'b0, pixel);
	end

	// Sum the decisions of this beat.
	always_comb begin
		incr.valid   = accept;
		incr.last    = at_row_last && at_col_last;
		incr.sum_inc = '0;
		incr.cnt_inc = '0;
		for (int i = 0; i < 4; i++) begin
			if (judge_en[i] && judge_hit[i]) begin
				incr.sum_inc = incr.sum_inc +
					glms_pkg::SUM_INC_W'(judge_center[i]) + glms_pkg::SUM_INC_W'(1);
				incr.cnt_inc = incr.cnt_inc + glms_pkg::CNT_INC_W'(1);
			end
		end
	end

	// Scan position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (at_col_last) begin
				col_q <= '0;
				row_q <= at_row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Window registers follow the accepted beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_center_q  <= '0;
			prev_up_q      <= '0;
			prev_pixel_q   <= '0;
			prev2_center_q <= '0;
			prev2_pixel_q  <= '0;
		end else if (clear) begin
			prev_center_q  <= '0;
			prev_up_q      <= '0;
			prev_pixel_q   <= '0;
			prev2_center_q <= '0;
			prev2_pixel_q  <= '0;
		end else if (accept) begin
			prev_center_q  <= rd_word.newer;
			prev_up_q      <= rd_word.older;
			prev_pixel_q   <= pixel;
			prev2_center_q <= prev_center_q;
			prev2_pixel_q  <= prev_pixel_q;
		end
	end

endmodule

// ----- rtl/core/glms_accum.sv -----
`timescale 1ns / 1ps

module glms_accum (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             clear,
	input  glms_pkg::incr_t                  incr,
	output logic                             take,
	output logic [glms_pkg::SUM_W-1:0]       risk_sum,
	output logic [glms_pkg::COUNT_W-1:0]     minima_count,
	output logic                             result_valid,
	input  logic                             result_ready
);

	localparam int SW = glms_pkg::SUM_W;
	localparam int CW = glms_pkg::COUNT_W;

	glms_pkg::incr_t incr_s1;
	logic [SW-1:0]   acc_sum_q;
	logic [CW-1:0]   acc_cnt_q;
	logic            result_valid_q;
	logic [SW-1:0]   risk_sum_q;
	logic [CW-1:0]   minima_count_q;

	logic          blocked;
	logic          finish;
	logic [SW:0]   sum_total;
	logic [CW:0]   cnt_total;
	logic [SW-1:0] sum_sat;
	logic [CW-1:0] cnt_sat;

	// A finished frame waits while the previous result has not been taken.
	assign blocked = incr_s1.valid && incr_s1.last && result_valid_q && !result_ready;
	assign take    = !blocked;
	assign finish  = incr_s1.valid && incr_s1.last && !blocked;

	// Saturating accumulate.
	always_comb begin
		sum_total = {1'b0, acc_sum_q} + (SW + 1)'(incr_s1.sum_inc);
		cnt_total = {1'b0, acc_cnt_q} + (CW + 1)'(incr_s1.cnt_inc);
		sum_sat   = sum_total[SW] ? '1 : sum_total[SW-1:0];
		cnt_sat   = cnt_total[CW] ? '1 : cnt_total[CW-1:0];
	end

	// Stage register, accumulators and result handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			incr_s1        <= '0;
			acc_sum_q      <= '0;
			acc_cnt_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (clear) begin
				acc_sum_q <= '0;
				acc_cnt_q <= '0;
			end else if (incr_s1.valid && !blocked) begin
				acc_sum_q <= incr_s1.last ? '0 : sum_sat;
				acc_cnt_q <= incr_s1.last ? '0 : cnt_sat;
			end
			if (!blocked) begin
				incr_s1 <= incr;
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (finish) begin
			risk_sum_q     <= sum_sat;
			minima_count_q <= cnt_sat;
		end
	end

	assign result_valid = result_valid_q;
	assign risk_sum     = risk_sum_q;
	assign minima_count = minima_count_q;

endmodule

// ----- rtl/core/grid_local_minimum_sum.sv -----
`timescale 1ns / 1ps
// Four-neighbor local minimum count and risk sum over a streamed frame.
// Throughput: one pixel beat per clock; each beat does one read and one write of the row store.
// Result path: the last pixel beat's increment passes the stage register, then the result register.
// A finished frame behind an untaken result stalls the pixel side until that result is taken.
// Reset: asynchronous, active low; frame size returns to 100 x 100, scan and totals clear.

module grid_local_minimum_sum #(
	parameter int MAX_WIDTH = glms_pkg::MAX_WIDTH_DEF,
	parameter int MAX_ROWS  = glms_pkg::MAX_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [glms_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [glms_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic [glms_pkg::HEIGHT_W-1:0]       height_digit,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [glms_pkg::SUM_W-1:0]          risk_sum,
	output logic [glms_pkg::COUNT_W-1:0]        minima_count
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [glms_pkg::CFG_W-1:0] frame_width_q;
	logic [glms_pkg::CFG_W-1:0] frame_rows_q;
	logic [31:0]                width_ext;
	logic [31:0]                rows_ext;
	logic [COL_W-1:0]           col_last;
	logic [ROW_W-1:0]           row_last;

	logic                accept;
	logic                take;
	logic                wr_en;
	logic                rd_en;
	logic [COL_W-1:0]    wr_addr;
	logic [COL_W-1:0]    rd_addr;
	glms_pkg::row_word_t wr_word;
	glms_pkg::row_word_t rd_word;
	glms_pkg::incr_t     incr;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= glms_pkg::FRAME_WIDTH_RESET;
			frame_rows_q  <= glms_pkg::FRAME_ROWS_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				glms_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				glms_pkg::REG_FRAME_ROWS: begin
					frame_rows_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Last column and last row, with zero read as one and large values clamped.
	assign width_ext = 32'(frame_width_q);
	assign rows_ext  = 32'(frame_rows_q);

	always_comb begin
		if (frame_width_q == '0) begin
			col_last = '0;
		end else if (width_ext > 32'(MAX_WIDTH)) begin
			col_last = COL_W'(MAX_WIDTH - 1);
		end else begin
			col_last = COL_W'(width_ext - 32'd1);
		end
		if (frame_rows_q == '0) begin
			row_last = '0;
		end else if (rows_ext > 32'(MAX_ROWS)) begin
			row_last = ROW_W'(MAX_ROWS - 1);
		end else begin
			row_last = ROW_W'(rows_ext - 32'd1);
		end
	end

	assign pixel_ready = take;
	assign accept      = pixel_valid && take;

	glms_row_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (COL_W)
	) u_row_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_word)
	);

	glms_scan #(
		.COL_W (COL_W),
		.ROW_W (ROW_W)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (cfg_write),
		.accept   (accept),
		.pixel    (height_digit),
		.col_last (col_last),
		.row_last (row_last),
		.rd_word  (rd_word),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_word  (wr_word),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.incr     (incr)
	);

	glms_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_write),
		.incr         (incr),
		.take         (take),
		.risk_sum     (risk_sum),
		.minima_count (minima_count),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

// ----- rtl/core/glms_checker.sv -----
`timescale 1ns / 1ps

module glms_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            pixel_valid,
	input logic                            pixel_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [glms_pkg::SUM_W-1:0]      risk_sum,
	input logic [glms_pkg::COUNT_W-1:0]    minima_count
);

	// A stalled result beat holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(risk_sum) &&
			$stable(minima_count))
	else $error("result beat changed while stalled");

	// Every minimum adds at least one to the sum.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (risk_sum >= glms_pkg::SUM_W'(minima_count)))
	else $error("risk sum below minima count");

	// A new result follows an accepted pixel beat, through the stage and result registers.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(pixel_valid && pixel_ready, 2))
	else $error("result appeared without a pixel beat");

	// The pixel side stalls only behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_ready |-> result_valid)
	else $error("pixel side stalled with no result waiting");

endmodule

bind grid_local_minimum_sum glms_checker u_glms_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_ready  (pixel_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.risk_sum     (risk_sum),
	.minima_count (minima_count)
);

// ----- tb/pit_tally_checker.sv -----
`timescale 1ns / 1ps

module pit_tally_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [glms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [glms_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            pixel_valid,
	input  logic                            pixel_ready,
	input  logic [glms_pkg::HEIGHT_W-1:0]   height_digit,
	input  logic                            result_valid,
	input  logic                            result_ready,
	input  logic [glms_pkg::SUM_W-1:0]      risk_sum,
	input  logic [glms_pkg::COUNT_W-1:0]    minima_count,
	output int                              outstanding_frames,
	output int                              mismatches
);

	localparam int MAX_W     = glms_pkg::MAX_WIDTH_DEF;
	localparam int MAX_H     = glms_pkg::MAX_ROWS_DEF;
	localparam int SUM_MAX   = (1 << glms_pkg::SUM_W) - 1;
	localparam int COUNT_MAX = (1 << glms_pkg::COUNT_W) - 1;
	// A missing neighbor is treated as a height above every real one.
	localparam int ABSENT    = 1 << glms_pkg::HEIGHT_W;

	typedef struct packed {
		logic [glms_pkg::SUM_W-1:0]   risk;
		logic [glms_pkg::COUNT_W-1:0] count;
	} frame_totals_t;

	logic [glms_pkg::CFG_W-1:0]    width_reg;
	logic [glms_pkg::CFG_W-1:0]    rows_reg;
	logic [glms_pkg::HEIGHT_W-1:0] older_row [MAX_W];
	logic [glms_pkg::HEIGHT_W-1:0] newer_row [MAX_W];
	logic [glms_pkg::HEIGHT_W-1:0] left_pixel;
	int unsigned                   col_pos;
	int unsigned                   row_pos;
	int unsigned                   sum_acc;
	int unsigned                   count_acc;
	int                            errors;
	frame_totals_t                 expected_totals [$];

	assign mismatches = errors;

	function automatic int unsigned effective_size(logic [glms_pkg::CFG_W-1:0] raw,
		int unsigned limit);
		if (raw == 0) begin
			return 1;
		end
		return (raw > limit) ? limit : raw;
	endfunction

	task automatic clear_frame();
		col_pos = 0;
		row_pos = 0;
		left_pixel = '0;
		sum_acc = 0;
		count_acc = 0;
	endtask

	// Credits the pixel when it is strictly lower than every existing neighbor.
	task automatic tally(int center, int up, int down, int left, int right);
		if (center < up && center < down && center < left && center < right) begin
			sum_acc = sum_acc + 1 + center;
			if (sum_acc > SUM_MAX) begin
				sum_acc = SUM_MAX;
			end
			if (count_acc < COUNT_MAX) begin
				count_acc++;
			end
		end
	endtask

	// Decides the pixel above the incoming one, shifts the row stores and,
	// on the frame's last pixel, settles the bottom row and queues the totals.
	task automatic fold_pixel(logic [glms_pkg::HEIGHT_W-1:0] px);
		int unsigned   w;
		int unsigned   h;
		int unsigned   c;
		int unsigned   r;
		int            center;
		int            up;
		int            left;
		int            right;
		frame_totals_t totals;
		w = effective_size(width_reg, MAX_W);
		h = effective_size(rows_reg, MAX_H);
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		if (r >= 1) begin
			center = newer_row[c];
			up = (r >= 2) ? int'(older_row[c]) : ABSENT;
			left = (c > 0) ? int'(left_pixel) : ABSENT;
			right = (c + 1 < w) ? int'(newer_row[c + 1]) : ABSENT;
			tally(center, up, px, left, right);
			left_pixel = center;
		end
		older_row[c] = newer_row[c];
		newer_row[c] = px;
		if (!(r + 1 == h && c + 1 == w)) begin
			c++;
			if (c == w) begin
				c = 0;
				r++;
			end
			col_pos = c;
			row_pos = r;
		end else begin
			for (c = 0; c < w; c++) begin
				up = (h >= 2) ? int'(older_row[c]) : ABSENT;
				left = (c > 0) ? int'(newer_row[c - 1]) : ABSENT;
				right = (c + 1 < w) ? int'(newer_row[c + 1]) : ABSENT;
				tally(newer_row[c], up, ABSENT, left, right);
			end
			totals.risk = sum_acc[glms_pkg::SUM_W-1:0];
			totals.count = count_acc[glms_pkg::COUNT_W-1:0];
			expected_totals.insert(expected_totals.size(), totals);
			clear_frame();
		end
	endtask

	// Result beats are checked before the same edge's pixel beat is folded in,
	// since any result seen here belongs to an earlier frame.
	always @(posedge clk or negedge arst_n) begin
		frame_totals_t want;
		if (!arst_n) begin
			width_reg = glms_pkg::FRAME_WIDTH_RESET;
			rows_reg = glms_pkg::FRAME_ROWS_RESET;
			clear_frame();
			expected_totals.delete();
			errors = 0;
			outstanding_frames <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_totals.size() == 0) begin
					$error("result beat with no frame pending: risk_sum=%0d minima_count=%0d",
						risk_sum, minima_count);
					errors++;
				end else begin
					want = expected_totals.pop_front();
					if (risk_sum !== want.risk) begin
						$error("risk_sum mismatch: expected %0d, got %0d", want.risk, risk_sum);
						errors++;
					end
					if (minima_count !== want.count) begin
						$error("minima_count mismatch: expected %0d, got %0d",
							want.count, minima_count);
						errors++;
					end
				end
			end
			if (cfg_write) begin
				if (cfg_index == glms_pkg::REG_FRAME_WIDTH) begin
					width_reg = cfg_data;
				end else if (cfg_index == glms_pkg::REG_FRAME_ROWS) begin
					rows_reg = cfg_data;
				end
				clear_frame();
			end
			if (pixel_valid && pixel_ready) begin
				fold_pixel(height_digit);
			end
			outstanding_frames <= expected_totals.size();
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int   SETTLE_CYCLES = 8;
	localparam int   HOLD_CYCLES   = 300;
	localparam int   PHASE_PIXELS  = 300;
	localparam int   SMALL_MAX     = 8;
	localparam int   FULL_WIDTH    = glms_pkg::MAX_WIDTH_DEF;
	localparam int   FULL_ROWS     = glms_pkg::MAX_ROWS_DEF;
	localparam int   MAX_DIGIT     = 9;
	localparam int   MAX_NIBBLE    = (1 << glms_pkg::HEIGHT_W) - 1;
	localparam int   LIMIT_NS      = 6_000_000;

	typedef enum int {FILL_DIGITS, FILL_NIBBLES, FILL_CHECKER, FILL_FLAT, FILL_TIES} fill_t;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_write = 1'b0;
	logic [glms_pkg::CFG_IDX_W-1:0]       cfg_index = glms_pkg::REG_FRAME_WIDTH;
	logic [glms_pkg::CFG_W-1:0]           cfg_data = '0;
	logic                                 pixel_valid = 1'b0;
	logic                                 pixel_ready;
	logic [glms_pkg::HEIGHT_W-1:0]        height_digit = '0;
	logic                                 result_valid;
	logic                                 result_ready = 1'b0;
	logic [glms_pkg::SUM_W-1:0]           risk_sum;
	logic [glms_pkg::COUNT_W-1:0]         minima_count;
	int                                   outstanding_frames;
	int                                   mismatches;
	int                                   send_idle_pct = 0;
	int                                   recv_idle_pct = 0;
	bit                                   hold_request = 1'b0;
	int                                   pixels_sent = 0;

	grid_local_minimum_sum dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.height_digit (height_digit),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.risk_sum     (risk_sum),
		.minima_count (minima_count)
	);

	pit_tally_checker u_tally (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.pixel_valid        (pixel_valid),
		.pixel_ready        (pixel_ready),
		.height_digit       (height_digit),
		.result_valid       (result_valid),
		.result_ready       (result_ready),
		.risk_sum           (risk_sum),
		.minima_count       (minima_count),
		.outstanding_frames (outstanding_frames),
		.mismatches         (mismatches)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	// Result side: random backpressure, or a long hold when one is requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Offers one pixel beat after a random gap. Valid is left high after the
	// beat is taken so back-to-back beats need no second assignment.
	task automatic send_pixel(logic [glms_pkg::HEIGHT_W-1:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		pixel_valid <= 1'b1;
		height_digit <= d;
		do begin
			@(posedge clk);
		end while (!pixel_ready);
		pixels_sent++;
	endtask

	// Waits until every queued frame total has been taken.
	task automatic drain_results();
		do begin
			@(posedge clk);
		end while (outstanding_frames != 0);
	endtask

	// Register writes only go out once the block has gone quiet.
	task automatic write_register(logic [glms_pkg::CFG_IDX_W-1:0] idx,
		logic [glms_pkg::CFG_W-1:0] value);
		pixel_valid <= 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_frame(logic [glms_pkg::CFG_W-1:0] w, logic [glms_pkg::CFG_W-1:0] h);
		write_register(glms_pkg::REG_FRAME_WIDTH, w);
		write_register(glms_pkg::REG_FRAME_ROWS, h);
	endtask

	// Sends the first pixel_total pixels of a frame w pixels wide.
	task automatic send_frame(int w, fill_t fill, int pixel_total);
		int                            base;
		int                            idx;
		logic [glms_pkg::HEIGHT_W-1:0] d;
		base = $urandom_range(0, MAX_DIGIT);
		for (idx = 0; idx < pixel_total; idx++) begin
			case (fill)
				FILL_DIGITS: begin
					d = glms_pkg::HEIGHT_W'($urandom_range(0, MAX_DIGIT));
				end
				FILL_NIBBLES: begin
					d = glms_pkg::HEIGHT_W'($urandom_range(0, MAX_NIBBLE));
				end
				FILL_CHECKER: begin
					d = (((idx / w) + (idx % w)) % 2 == 0) ? glms_pkg::HEIGHT_W'(base)
						: glms_pkg::HEIGHT_W'(base + $urandom_range(1, MAX_NIBBLE - base));
				end
				FILL_FLAT: begin
					d = glms_pkg::HEIGHT_W'(base);
				end
				default: begin
					d = glms_pkg::HEIGHT_W'($urandom_range(0, 1));
				end
			endcase
			send_pixel(d);
		end
	endtask

	initial begin
		int phase;
		int w_raw;
		int h_raw;
		int w_eff;
		int h_eff;
		int frames;
		int idx;
		int area;
		fill_t fill;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 27;
		recv_idle_pct = 62;
		@(posedge clk);

		// A frame cut short under the reset size, restarted by a zero size
		// that acts as a single pixel frame.
		send_pixel(4'd15);
		send_pixel(4'd0);
		send_pixel(4'd9);
		set_frame(8'd0, 8'd0);
		send_pixel(4'd0);
		send_pixel(4'd15);

		// A lone pit in the middle of a 3 x 3 frame; the equal edges are not pits.
		set_frame(8'd3, 8'd3);
		for (idx = 0; idx < 9; idx++) begin
			send_pixel((idx == 4) ? 4'd0 : 4'd9);
		end

		// Single row and single column frames.
		set_frame(8'd3, 8'd1);
		send_pixel(4'd5);
		send_pixel(4'd5);
		send_pixel(4'd4);
		set_frame(8'd1, 8'd3);
		send_pixel(4'd2);
		send_pixel(4'd1);
		send_pixel(4'd3);

		// Heights above nine in a 2 x 2 frame.
		set_frame(8'd2, 8'd2);
		send_pixel(4'd15);
		send_pixel(4'd14);
		send_pixel(4'd14);
		send_pixel(4'd13);

		// One-pixel frames while the result side holds off, so that results
		// pile up and the pixel side stalls; then a full pause.
		set_frame(8'd1, 8'd1);
		hold_request = 1'b1;
		for (idx = 0; idx < 16; idx++) begin
			send_pixel(glms_pkg::HEIGHT_W'($urandom_range(0, MAX_NIBBLE)));
		end
		pixel_valid <= 1'b0;
		drain_results();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 27;
					recv_idle_pct = 62;
					w_raw = FULL_WIDTH;
					h_raw = $urandom_range(1, 2);
				end
				1: begin
					send_idle_pct = 62;
					recv_idle_pct = 27;
					w_raw = $urandom_range(0, 1);
					h_raw = FULL_ROWS;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					w_raw = $urandom_range(FULL_WIDTH + 1, 255);
					h_raw = $urandom_range(0, 2);
				end
			endcase
			frames = 1;
			while (pixels_sent < (phase + 1) * PHASE_PIXELS + 24) begin
				set_frame(glms_pkg::CFG_W'(w_raw), glms_pkg::CFG_W'(h_raw));
				w_eff = (w_raw == 0) ? 1 : ((w_raw > FULL_WIDTH) ? FULL_WIDTH : w_raw);
				h_eff = (h_raw == 0) ? 1 : ((h_raw > FULL_ROWS) ? FULL_ROWS : h_raw);
				area = w_eff * h_eff;
				for (idx = 0; idx < frames; idx++) begin
					fill = fill_t'($urandom_range(0, 4));
					// Now and then a frame is broken off; the next size
					// write restarts the scan.
					if (area > 1 && $urandom_range(99) < 8) begin
						send_frame(w_eff, fill, $urandom_range(1, area - 1));
						break;
					end
					send_frame(w_eff, fill, area);
				end
				w_raw = $urandom_range(1, SMALL_MAX);
				h_raw = $urandom_range(1, SMALL_MAX);
				frames = $urandom_range(1, 4);
			end
		end

		pixel_valid <= 1'b0;
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
